// ----- hw/rtl/arm_pkg.sv -----
// Shared types, constants and functions of the auto-ranging meter front end.
// Used by every module under hw/rtl; depends on nothing else.
package arm_pkg;

   typedef enum logic [1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_UP     = 2'd1,
      CMD_DOWN   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef logic [0:0] csr_index_type;

   localparam csr_index_type CSR_UPPER_THRESHOLD = 1'b0;
   localparam csr_index_type CSR_LOWER_THRESHOLD = 1'b1;

   localparam logic [9:0] UPPER_THRESHOLD_RESET = 10'd800;
   localparam logic [9:0] LOWER_THRESHOLD_RESET = 10'd80;

   localparam logic [2:0] NUM_RANGES = 3'd5;
   localparam logic [2:0] RANGE_MIN  = 3'd1;

   // Word after scaling: the sample and its reading in display counts.
   typedef struct packed {
      logic        valid;
      cmd_type     command;
      logic [9:0]  sample;
      logic [11:0] reading;
   } scaled_type;

   // Word after the first digit split: reading / 100 and reading % 100.
   typedef struct packed {
      logic        valid;
      cmd_type     command;
      logic [9:0]  sample;
      logic [11:0] reading;
      logic [4:0]  hundreds_full;
      logic [6:0]  rest;
   } digits_type;

   function automatic logic [6:0] seg_of(input logic [3:0] digit);
      logic [6:0] code;
      unique case (digit)
         4'd0:    code = 7'b0111111;
         4'd1:    code = 7'b0000110;
         4'd2:    code = 7'b1011011;
         4'd3:    code = 7'b1001111;
         4'd4:    code = 7'b1100110;
         4'd5:    code = 7'b1101101;
         4'd6:    code = 7'b1111100;
         4'd7:    code = 7'b0000111;
         4'd8:    code = 7'b1111111;
         4'd9:    code = 7'b1101111;
         default: code = 7'b0000000;
      endcase
      return code;
   endfunction

endpackage

// ----- hw/rtl/arm_scale.sv -----
// Input register and sample scaling: reading = floor(sample * 2560 / 1023).
// Depends on arm_pkg.
module arm_scale
   import arm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic       req_valid,
   input  logic [1:0] req_command,
   input  logic [9:0] req_sample,
   output scaled_type scaled
);

   logic        in_valid_ff;
   cmd_type     in_command_ff;
   logic [9:0]  in_sample_ff;
   scaled_type  scaled_ff;
   scaled_type  scaled_in;

   logic [21:0] product_x;
   logic [31:0] product_r;
   logic [11:0] quotient_est;
   logic [21:0] back_product;
   logic [21:0] remainder;

   // The reciprocal of 1023 is taken as 1025 / 2^20, which never overshoots and
   // falls short by at most one; one compare on the remainder corrects it.
   always_comb begin
      product_x    = {1'b0, in_sample_ff, 11'b0} + {3'b0, in_sample_ff, 9'b0};
      product_r    = {product_x, 10'b0} + {10'b0, product_x};
      quotient_est = product_r[31:20];
      back_product = {quotient_est, 10'b0} - {10'b0, quotient_est};
      remainder    = product_x - back_product;
      scaled_in.valid   = in_valid_ff;
      scaled_in.command = in_command_ff;
      scaled_in.sample  = in_sample_ff;
      scaled_in.reading = quotient_est + {11'b0, (remainder >= 22'd1023)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         scaled_ff.valid <= 1'b0;
      end else if (advance) begin
         in_valid_ff   <= req_valid;
         in_command_ff <= cmd_type'(req_command);
         in_sample_ff  <= req_sample;
         scaled_ff     <= scaled_in;
      end
   end

   assign scaled = scaled_ff;

endmodule

// ----- hw/rtl/arm_digits.sv -----
// First decimal split of the scaled reading into reading / 100 and reading % 100.
// Depends on arm_pkg.
module arm_digits
   import arm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  scaled_type scaled,
   output digits_type digits
);

   digits_type  digits_ff;
   digits_type  digits_in;
   logic [24:0] div_product;
   logic [11:0] hundreds_back;
   logic [11:0] rest_full;

   // Multiplying by 5243 / 2^19 gives an exact division by 100 for any reading.
   always_comb begin
      div_product   = {13'b0, scaled.reading} * 25'd5243;
      hundreds_back = {7'b0, div_product[23:19]} * 12'd100;
      rest_full     = scaled.reading - hundreds_back;
      digits_in.valid         = scaled.valid;
      digits_in.command       = scaled.command;
      digits_in.sample        = scaled.sample;
      digits_in.reading       = scaled.reading;
      digits_in.hundreds_full = div_product[23:19];
      digits_in.rest          = rest_full[6:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digits_ff.valid <= 1'b0;
      end else if (advance) begin
         digits_ff <= digits_in;
      end
   end

   assign digits = digits_ff;

endmodule

// ----- hw/rtl/arm_ctrl.sv -----
// Threshold registers, range and held-reading state, display encoding and the
// result register. Depends on arm_pkg.
module arm_ctrl
   import arm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  digits_type  digits,
   input  logic        csr_write_enable,
   input  logic [0:0]  csr_index,
   input  logic [9:0]  csr_write_data,
   output logic        rsp_valid,
   output logic [4:0]  rsp_relay_select,
   output logic [2:0]  rsp_range_now,
   output logic [11:0] rsp_reading,
   output logic [6:0]  rsp_seg_thousands,
   output logic [6:0]  rsp_seg_hundreds,
   output logic [6:0]  rsp_seg_tens,
   output logic [6:0]  rsp_seg_ones,
   output logic [2:0]  rsp_point_digit
);

   logic [9:0]  upper_ff;
   logic [9:0]  lower_ff;
   logic [2:0]  range_ff;
   logic [2:0]  range_in;
   logic [11:0] held_reading_ff;
   logic [11:0] held_reading_in;
   logic [4:0]  held_hundreds_ff;
   logic [4:0]  held_hundreds_in;
   logic [6:0]  held_rest_ff;
   logic [6:0]  held_rest_in;

   logic        rsp_valid_ff;
   logic [4:0]  relay_ff;
   logic [2:0]  range_now_ff;
   logic [11:0] reading_ff;
   logic [6:0]  seg_thousands_ff;
   logic [6:0]  seg_hundreds_ff;
   logic [6:0]  seg_tens_ff;
   logic [6:0]  seg_ones_ff;

   logic        up_ok;
   logic        down_ok;
   logic        take_item;
   logic [11:0] th_product;
   logic [1:0]  thousands;
   logic [4:0]  hundreds_wide;
   logic [13:0] te_product;
   logic [3:0]  tens;
   logic [6:0]  ones_wide;
   logic [4:0]  relay_in;

   always_comb begin
      up_ok            = (range_ff < NUM_RANGES);
      down_ok          = (range_ff > RANGE_MIN);
      take_item        = digits.valid && advance;
      range_in         = range_ff;
      held_reading_in  = held_reading_ff;
      held_hundreds_in = held_hundreds_ff;
      held_rest_in     = held_rest_ff;
      case (digits.command)
         CMD_SAMPLE: begin
            if (up_ok && (digits.sample >= upper_ff)) begin
               range_in = range_ff + 3'd1;
            end else if (down_ok && (digits.sample < lower_ff)) begin
               range_in = range_ff - 3'd1;
            end else begin
               held_reading_in  = digits.reading;
               held_hundreds_in = digits.hundreds_full;
               held_rest_in     = digits.rest;
            end
         end
         CMD_UP: begin
            if (up_ok) begin
               range_in = range_ff + 3'd1;
            end
         end
         CMD_DOWN: begin
            if (down_ok) begin
               range_in = range_ff - 3'd1;
            end
         end
         default: begin
            range_in = range_ff;
         end
      endcase

      // Division by ten of values below 179 is exact as a multiply by 103 / 2^10.
      th_product    = {7'b0, held_hundreds_in} * 12'd103;
      thousands     = th_product[11:10];
      hundreds_wide = held_hundreds_in - ({3'b0, thousands} * 5'd10);
      te_product    = {7'b0, held_rest_in} * 14'd103;
      tens          = te_product[13:10];
      ones_wide     = held_rest_in - ({3'b0, tens} * 7'd10);
      relay_in      = 5'd1 << (range_in - 3'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff         <= UPPER_THRESHOLD_RESET;
         lower_ff         <= LOWER_THRESHOLD_RESET;
         range_ff         <= RANGE_MIN;
         held_reading_ff  <= 12'd0;
         held_hundreds_ff <= 5'd0;
         held_rest_ff     <= 7'd0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_UPPER_THRESHOLD: upper_ff <= csr_write_data;
               CSR_LOWER_THRESHOLD: lower_ff <= csr_write_data;
               default:             upper_ff <= upper_ff;
            endcase
         end
         if (take_item) begin
            range_ff         <= range_in;
            held_reading_ff  <= held_reading_in;
            held_hundreds_ff <= held_hundreds_in;
            held_rest_ff     <= held_rest_in;
         end
         if (advance) begin
            rsp_valid_ff <= digits.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         relay_ff         <= relay_in;
         range_now_ff     <= range_in;
         reading_ff       <= held_reading_in;
         seg_thousands_ff <= seg_of({2'b0, thousands});
         seg_hundreds_ff  <= seg_of(hundreds_wide[3:0]);
         seg_tens_ff      <= seg_of(tens);
         seg_ones_ff      <= seg_of(ones_wide[3:0]);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_relay_select  = relay_ff;
   assign rsp_range_now     = range_now_ff;
   assign rsp_reading       = reading_ff;
   assign rsp_seg_thousands = seg_thousands_ff;
   assign rsp_seg_hundreds  = seg_hundreds_ff;
   assign rsp_seg_tens      = seg_tens_ff;
   assign rsp_seg_ones      = seg_ones_ff;
   assign rsp_point_digit   = range_now_ff;

endmodule

// ----- hw/rtl/autorange_meter_front_end.sv -----
// Top level of the auto-ranging meter front end: range control and display encoder.
// Instantiates arm_scale, arm_digits and arm_ctrl; depends on arm_pkg.
//
// The block takes one word per clock and returns one result word for each, in order.
// A word passes through four registers (input, scaled reading, decimal split,
// result); the last of them drives the result ports directly. The whole
// pipeline moves together: it stalls only while a result waits on rsp_stall,
// so with the result side never stalling a word is taken in every cycle. The
// range and held reading are updated as a word enters the result register, so
// every result reflects all earlier words. Threshold writes take effect on the
// next word that reaches the result register and should be made while the
// block is empty. There is no start-up pass after reset.
module autorange_meter_front_end
   import arm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [9:0]  req_sample,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_relay_select,
   output logic [2:0]  rsp_range_now,
   output logic [11:0] rsp_reading,
   output logic [6:0]  rsp_seg_thousands,
   output logic [6:0]  rsp_seg_hundreds,
   output logic [6:0]  rsp_seg_tens,
   output logic [6:0]  rsp_seg_ones,
   output logic [2:0]  rsp_point_digit,
   input  logic        csr_write_enable,
   input  logic [0:0]  csr_index,
   input  logic [9:0]  csr_write_data
);

   logic       advance;
   scaled_type scaled;
   digits_type digits;

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   arm_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_sample  (req_sample),
      .scaled      (scaled)
   );

   arm_digits u_digits (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .scaled  (scaled),
      .digits  (digits)
   );

   arm_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .advance           (advance),
      .digits            (digits),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_relay_select  (rsp_relay_select),
      .rsp_range_now     (rsp_range_now),
      .rsp_reading       (rsp_reading),
      .rsp_seg_thousands (rsp_seg_thousands),
      .rsp_seg_hundreds  (rsp_seg_hundreds),
      .rsp_seg_tens      (rsp_seg_tens),
      .rsp_seg_ones      (rsp_seg_ones),
      .rsp_point_digit   (rsp_point_digit)
   );

endmodule

// ----- hw/rtl/arm_checker.sv -----
// Port-level checks of the auto-ranging meter front end, bound to its top level.
// Depends on autorange_meter_front_end and arm_pkg.
module arm_checker
   import arm_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [4:0]  rsp_relay_select,
   input logic [2:0]  rsp_range_now,
   input logic [11:0] rsp_reading,
   input logic [2:0]  rsp_point_digit
);

   // A waiting result word stays valid, with its reading unchanged, until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_reading))
      else $error("result word dropped or changed while stalled");

   // The relay drive matches the reported range.
   a_relay_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot(rsp_relay_select)
         && rsp_relay_select == (5'd1 << (rsp_range_now - 3'd1)))
      else $error("relay drive does not match range");

   // The range stays within its limits and the decimal point follows it.
   a_range_point: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_range_now >= RANGE_MIN && rsp_range_now <= NUM_RANGES
         && rsp_point_digit == rsp_range_now)
      else $error("range or decimal point out of place");

   // The held reading never exceeds full scale.
   a_reading_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_reading <= 12'd2560)
      else $error("reading above full scale");

   // Input is held off exactly while a result is stalled.
   a_req_backpressure: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow result stall");

endmodule

bind autorange_meter_front_end arm_checker u_arm_checker (.*);

// ----- tb/tb_autorange_meter_front_end.sv -----
// Self-checking testbench of autorange_meter_front_end: a directed table, then random words
// under random idling on both sides, each result checked against the table or a built-in
// range model. Depends on arm_pkg and the RTL of the block; reads no files.
module tb_autorange_meter_front_end;
   import arm_pkg::*;

   localparam int PLAN_LEN = 27;
   localparam int PHASES = 10;
   localparam int PHASE_WORDS = 125;
   localparam int LONG_HOLD = 80;
   localparam int SETTLE_CYCLES = 10;
   localparam int CYCLE_LIMIT = 300000;
   localparam int READ_SCALE = 2560;
   localparam int ADC_FULL = 1023;

   localparam logic [9:0][6:0] SEVEN_SEG = {
      7'b1101111, 7'b1111111, 7'b0000111, 7'b1111100, 7'b1101101,
      7'b1100110, 7'b1001111, 7'b1011011, 7'b0000110, 7'b0111111
   };

   typedef struct packed {
      logic [4:0]  relay_select;
      logic [2:0]  range_now;
      logic [11:0] reading;
      logic [6:0]  seg_thousands;
      logic [6:0]  seg_hundreds;
      logic [6:0]  seg_tens;
      logic [6:0]  seg_ones;
      logic [2:0]  point_digit;
   } meter_word_type;

   typedef struct packed {
      logic        set_thresholds;
      logic [9:0]  upper;
      logic [9:0]  lower;
      cmd_type     command;
      logic [9:0]  sample;
      logic        typed;
      logic [2:0]  want_range;
      logic [11:0] want_reading;
   } plan_row_type;

   // Rows that set thresholds write both registers; typed rows carry the range and reading.
   localparam plan_row_type [0:PLAN_LEN-1] PLAN = '{
      '{1'b0, 10'd0, 10'd0, CMD_NONE,   10'd1023, 1'b1, 3'd1, 12'd0},
      '{1'b0, 10'd0, 10'd0, CMD_DOWN,   10'd0,    1'b1, 3'd1, 12'd0},
      '{1'b0, 10'd0, 10'd0, CMD_SAMPLE, 10'd0,    1'b1, 3'd1, 12'd0},
      '{1'b0, 10'd0, 10'd0, CMD_SAMPLE, 10'd1023, 1'b1, 3'd2, 12'd0},
      '{1'b0, 10'd0, 10'd0, CMD_SAMPLE, 10'd1023, 1'b1, 3'd3, 12'd0},
      '{1'b0, 10'd0, 10'd0, CMD_UP,     10'd0,    1'b1, 3'd4, 12'd0},
      '{1'b0, 10'd0, 10'd0, CMD_UP,     10'd1023, 1'b1, 3'd5, 12'd0},
      '{1'b0, 10'd0, 10'd0, CMD_UP,     10'd0,    1'b1, 3'd5, 12'd0},
      '{1'b0, 10'd0, 10'd0, CMD_SAMPLE, 10'd1023, 1'b1, 3'd5, 12'd2560},
      '{1'b0, 10'd0, 10'd0, CMD_SAMPLE, 10'd0,    1'b1, 3'd4, 12'd2560},
      '{1'b0, 10'd0, 10'd0, CMD_DOWN,   10'd0,    1'b1, 3'd3, 12'd2560},
      '{1'b0, 10'd0, 10'd0, CMD_DOWN,   10'd1023, 1'b1, 3'd2, 12'd2560},
      '{1'b0, 10'd0, 10'd0, CMD_DOWN,   10'd0,    1'b1, 3'd1, 12'd2560},
      '{1'b0, 10'd0, 10'd0, CMD_DOWN,   10'd0,    1'b1, 3'd1, 12'd2560},
      '{1'b0, 10'd0, 10'd0, CMD_SAMPLE, 10'd500,  1'b0, 3'd0, 12'd0},
      '{1'b0, 10'd0, 10'd0, CMD_SAMPLE, 10'd799,  1'b0, 3'd0, 12'd0},
      '{1'b0, 10'd0, 10'd0, CMD_SAMPLE, 10'd800,  1'b0, 3'd0, 12'd0},
      '{1'b0, 10'd0, 10'd0, CMD_SAMPLE, 10'd80,   1'b0, 3'd0, 12'd0},
      '{1'b0, 10'd0, 10'd0, CMD_SAMPLE, 10'd79,   1'b0, 3'd0, 12'd0},
      '{1'b0, 10'd0, 10'd0, CMD_SAMPLE, 10'h2AA,  1'b0, 3'd0, 12'd0},
      '{1'b0, 10'd0, 10'd0, CMD_SAMPLE, 10'h155,  1'b0, 3'd0, 12'd0},
      '{1'b1, 10'd100, 10'd900, CMD_SAMPLE, 10'd0, 1'b0, 3'd0, 12'd0},
      '{1'b0, 10'd0, 10'd0, CMD_SAMPLE, 10'd500,  1'b0, 3'd0, 12'd0},
      '{1'b0, 10'd0, 10'd0, CMD_UP,     10'd0,    1'b0, 3'd0, 12'd0},
      '{1'b0, 10'd0, 10'd0, CMD_UP,     10'd0,    1'b0, 3'd0, 12'd0},
      '{1'b0, 10'd0, 10'd0, CMD_UP,     10'd0,    1'b0, 3'd0, 12'd0},
      '{1'b0, 10'd0, 10'd0, CMD_SAMPLE, 10'd500,  1'b0, 3'd0, 12'd0}
   };

   logic          clock;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic [1:0]    req_command = CMD_NONE;
   logic [9:0]    req_sample = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [4:0]    rsp_relay_select;
   logic [2:0]    rsp_range_now;
   logic [11:0]   rsp_reading;
   logic [6:0]    rsp_seg_thousands;
   logic [6:0]    rsp_seg_hundreds;
   logic [6:0]    rsp_seg_tens;
   logic [6:0]    rsp_seg_ones;
   logic [2:0]    rsp_point_digit;
   logic          csr_write_enable = 1'b0;
   csr_index_type csr_index = CSR_UPPER_THRESHOLD;
   logic [9:0]    csr_write_data = '0;

   logic [2:0]     meter_range;
   logic [11:0]    meter_held;
   logic [9:0]     upper_thr;
   logic [9:0]     lower_thr;
   meter_word_type expected_words[$];
   int             mismatch_count = 0;
   int             cycle_count = 0;
   bit             long_hold_req = 1'b0;

   autorange_meter_front_end dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_sample(req_sample),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_relay_select(rsp_relay_select),
      .rsp_range_now(rsp_range_now),
      .rsp_reading(rsp_reading),
      .rsp_seg_thousands(rsp_seg_thousands),
      .rsp_seg_hundreds(rsp_seg_hundreds),
      .rsp_seg_tens(rsp_seg_tens),
      .rsp_seg_ones(rsp_seg_ones),
      .rsp_point_digit(rsp_point_digit),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic meter_word_type display_word(input logic [2:0] rng,
                                                   input logic [11:0] rdg);
      meter_word_type w;
      int value;
      value = int'(rdg);
      w.relay_select = 5'(1) << (rng - 3'd1);
      w.range_now = rng;
      w.reading = rdg;
      w.seg_thousands = SEVEN_SEG[(value / 1000) % 10];
      w.seg_hundreds = SEVEN_SEG[(value / 100) % 10];
      w.seg_tens = SEVEN_SEG[(value / 10) % 10];
      w.seg_ones = SEVEN_SEG[value % 10];
      w.point_digit = rng;
      return w;
   endfunction

   task automatic advance_meter(input logic [1:0] cmd, input logic [9:0] smp,
                                output meter_word_type w);
      case (cmd)
         CMD_SAMPLE: begin
            if (meter_range < NUM_RANGES && smp >= upper_thr) begin
               meter_range = meter_range + 3'd1;
            end else if (meter_range > RANGE_MIN && smp < lower_thr) begin
               meter_range = meter_range - 3'd1;
            end else begin
               meter_held = 12'((int'(smp) * READ_SCALE) / ADC_FULL);
            end
         end
         CMD_UP: begin
            if (meter_range < NUM_RANGES) meter_range = meter_range + 3'd1;
         end
         CMD_DOWN: begin
            if (meter_range > RANGE_MIN) meter_range = meter_range - 3'd1;
         end
         default: begin
         end
      endcase
      w = display_word(meter_range, meter_held);
   endtask

   // Called at a rising edge; returns at the edge where the word was taken.
   task automatic send_word(input logic [1:0] cmd, input logic [9:0] smp, input int gap,
                            input logic typed, input logic [2:0] rng, input logic [11:0] rdg);
      meter_word_type want;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_sample <= smp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      advance_meter(cmd, smp, want);
      if (typed) want = display_word(rng, rdg);
      expected_words.push_back(want);
   endtask

   task automatic drain(input int settle);
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_thresholds(input logic [9:0] upper, input logic [9:0] lower);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_UPPER_THRESHOLD;
      csr_write_data <= upper;
      @(posedge clock);
      csr_index <= CSR_LOWER_THRESHOLD;
      csr_write_data <= lower;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      upper_thr = upper;
      lower_thr = lower;
   endtask

   function automatic logic [9:0] near_threshold(input logic [9:0] thr);
      int v;
      v = int'(thr) + int'($urandom_range(0, 3)) - 2;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      return 10'(v);
   endfunction

   task automatic pick_word(output logic [1:0] cmd, output logic [9:0] smp);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) cmd = CMD_UP;
      else if (roll < 20) cmd = CMD_DOWN;
      else if (roll < 25) cmd = CMD_NONE;
      else cmd = CMD_SAMPLE;
      case ($urandom_range(0, 3))
         0: smp = 10'($urandom);
         1: smp = near_threshold(upper_thr);
         2: smp = near_threshold(lower_thr);
         default: smp = ($urandom_range(0, 1) == 0) ? 10'd0 : 10'd1023;
      endcase
   endtask

   initial begin : stimulus
      logic [1:0] cmd;
      logic [9:0] smp;
      int gap;
      meter_range = RANGE_MIN;
      meter_held = '0;
      upper_thr = UPPER_THRESHOLD_RESET;
      lower_thr = LOWER_THRESHOLD_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < PLAN_LEN; i++) begin
         if (PLAN[i].set_thresholds) begin
            drain(SETTLE_CYCLES);
            write_thresholds(PLAN[i].upper, PLAN[i].lower);
         end else begin
            send_word(PLAN[i].command, PLAN[i].sample, $urandom_range(0, 11),
                      PLAN[i].typed, PLAN[i].want_range, PLAN[i].want_reading);
         end
      end
      for (int phase = 0; phase < PHASES; phase++) begin
         drain(SETTLE_CYCLES);
         case (phase)
            0: write_thresholds(UPPER_THRESHOLD_RESET, LOWER_THRESHOLD_RESET);
            1: write_thresholds(10'd0, 10'd0);
            2: write_thresholds(10'd1023, 10'd1023);
            3: write_thresholds(10'd0, 10'd1023);
            4: write_thresholds(10'd1023, 10'd0);
            5: write_thresholds(10'd512, 10'd511);
            default: write_thresholds(10'($urandom), 10'($urandom));
         endcase
         for (int n = 0; n < PHASE_WORDS; n++) begin
            // The receiver holds off while words keep coming, so the pipeline backs up.
            if (phase == 1 && n == 20) long_hold_req = 1'b1;
            if (phase == 6 && n == 60) drain(1);
            pick_word(cmd, smp);
            gap = (phase % 3 == 1) ? 0 : $urandom_range(0, 11);
            send_word(cmd, smp, gap, 1'b0, 3'd0, 12'd0);
         end
      end
      drain(SETTLE_CYCLES);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin : result_side
      int hold;
      int calm_left;
      calm_left = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold = LONG_HOLD;
         end else if (calm_left > 0) begin
            calm_left--;
            hold = 0;
         end else if ($urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(20, 60);
            hold = 0;
         end else begin
            hold = $urandom_range(0, 11);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      meter_word_type got;
      meter_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_relay_select, rsp_range_now, rsp_reading, rsp_seg_thousands,
                 rsp_seg_hundreds, rsp_seg_tens, rsp_seg_ones, rsp_point_digit};
         if (expected_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected result word: range %0d reading %0d",
                        got.range_now, got.reading);
            end
         end else begin
            want = expected_words.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("expected: relay %b range %0d reading %0d seg %h %h %h %h point %0d",
                           want.relay_select, want.range_now, want.reading,
                           want.seg_thousands, want.seg_hundreds, want.seg_tens,
                           want.seg_ones, want.point_digit);
                  $display("actual:   relay %b range %0d reading %0d seg %h %h %h %h point %0d",
                           got.relay_select, got.range_now, got.reading,
                           got.seg_thousands, got.seg_hundreds, got.seg_tens,
                           got.seg_ones, got.point_digit);
               end
            end
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

endmodule
